>>> rtl/core/sph_trapped_air_colorfield_accum_core_assert.svh
// Assertion macros shared by the trapped-air and colour-field accumulator RTL.
`ifndef SPH_TRAPPED_AIR_COLORFIELD_ACCUM_CORE_ASSERT_SVH
`define SPH_TRAPPED_AIR_COLORFIELD_ACCUM_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPH_TACF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sph_tacf assertion failed");

// Next-cycle implication, checked outside reset.
`define SPH_TACF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sph_tacf assertion failed");

`endif

>>> rtl/core/sph_tacf_pkg.sv
// Shared types and constants of the trapped-air and colour-field accumulator.
package sph_tacf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_SMOOTHING_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLOR_SCALE          = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] SMOOTHING_LENGTH_RESET     = 31'd65536;
   localparam logic [CSR_DATA_WIDTH-1:0] INV_SMOOTHING_LENGTH_RESET = 31'd65536;
   localparam logic [CSR_DATA_WIDTH-1:0] COLOR_SCALE_RESET          = 31'd27381;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   // Request to one of the serial arithmetic units.
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [31:0] b;
   } unit_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } unit_rsp_type;

endpackage

>>> rtl/core/sph_tacf_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module sph_tacf_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  sph_tacf_pkg::unit_req_type req,
   output sph_tacf_pkg::unit_rsp_type rsp
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (b_ff == 32'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[62:0], 1'b0};
            b_in = {1'b0, b_ff[31:1]};
         end
      end else if (req.start) begin
         acc_in  = 64'd0;
         a_in    = req.a;
         b_in    = req.b;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

>>> rtl/core/sph_tacf_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module sph_tacf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  sph_tacf_pkg::unit_req_type req,
   output sph_tacf_pkg::unit_rsp_type rsp
);

   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;

   // The dividend shifts out of the top of the quotient register as quotient bits enter below.
   assign rem_sh  = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         rem_in  = 32'd0;
         quo_in  = req.a;
         dvs_in  = req.b;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quo_ff;

endmodule

>>> rtl/core/sph_tacf_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module sph_tacf_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  sph_tacf_pkg::unit_req_type req,
   output sph_tacf_pkg::unit_rsp_type rsp
);

   logic [63:0] rad_ff, rad_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic [34:0] rem_sub;

   assign rem_sh  = {rem_ff, rad_ff[63:62]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign rem_sub = rem_sh - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[32:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[32:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         rad_in  = req.a;
         rem_in  = 33'd0;
         root_in = 32'd0;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = {32'd0, root_ff};

endmodule

>>> rtl/core/sph_trapped_air_colorfield_accum_core.sv
// A self pair goes from idle straight to the end state; other pairs take a time set by the
// serial multiplier (which stops once no set bits remain in its second operand), the
// divider and the square root unit, all driven by one sequencer. A last pair's sums are
// registered into the output beat when the end state is left; it waits on an unaccepted beat.
// Throughput: one pair at a time; the next pair is taken once the sequencer is idle.
// Synchronous active-high reset clears both sums, the output beat and the registers
// to their default values.
`include "sph_trapped_air_colorfield_accum_core_assert.svh"

module sph_trapped_air_colorfield_accum_core #(
   parameter int FRAC_BITS = sph_tacf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [31:0]                       req_rel_pos_x,
   input  logic signed [31:0]                       req_rel_pos_y,
   input  logic signed [31:0]                       req_rel_pos_z,
   input  logic signed [31:0]                       req_rel_vel_x,
   input  logic signed [31:0]                       req_rel_vel_y,
   input  logic signed [31:0]                       req_rel_vel_z,
   input  logic [31:0]                              req_neighbour_density,
   input  logic                                     req_self_pair,
   input  logic                                     req_last_neighbour,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [31:0]                              rsp_trapped_air_sum,
   output logic [31:0]                              rsp_color_field_sum,
   input  logic                                     csr_we,
   input  logic [sph_tacf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam logic [63:0] FX_ONE = 64'd1 << FRAC_BITS;
   localparam logic [63:0] FX_TWO = 64'd2 << FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_SQP, S_RTP, S_SQV, S_RTV, S_MQ, S_CHK, S_DV, S_DP, S_MD, S_ECALC,
      S_ME, S_MW, S_CCHK, S_MT2, S_MT4, S_MK, S_MC, S_DC, S_END
   } state_type;

   typedef enum logic [1:0] {OP_NONE, OP_MUL, OP_DIV, OP_SQRT} op_type;

   // Configuration registers.
   logic [30:0] smooth_ff, inv_smooth_ff, color_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff      <= sph_tacf_pkg::SMOOTHING_LENGTH_RESET;
         inv_smooth_ff  <= sph_tacf_pkg::INV_SMOOTHING_LENGTH_RESET;
         color_scale_ff <= sph_tacf_pkg::COLOR_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sph_tacf_pkg::CSR_SMOOTHING_LENGTH:     smooth_ff      <= csr_wdata;
            sph_tacf_pkg::CSR_INV_SMOOTHING_LENGTH: inv_smooth_ff  <= csr_wdata;
            sph_tacf_pkg::CSR_COLOR_SCALE:          color_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type   state_ff, state_in;
   logic        issued_ff, issued_in;
   logic [1:0]  k_ff, k_in;
   logic [31:0] pmag_ff [3];
   logic [31:0] pmag_in [3];
   logic [31:0] vmag_ff [3];
   logic [31:0] vmag_in [3];
   logic [2:0]  pneg_ff, pneg_in;
   logic [2:0]  vneg_ff, vneg_in;
   logic [31:0] rho_ff, rho_in;
   logic        last_ff, last_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] mv_ff, mv_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] uv_ff, uv_in;
   logic [63:0] up_ff, up_in;
   logic        uneg_ff, uneg_in;
   logic [63:0] dot_ff, dot_in;
   logic [31:0] e_ff, e_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [31:0] ta_acc_ff, ta_acc_in;
   logic [31:0] cf_acc_ff, cf_acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_ta_ff, rsp_ta_in;
   logic [31:0] rsp_cf_ff, rsp_cf_in;

   op_type                     op_kind;
   logic [63:0]                op_a;
   logic [31:0]                op_b;
   sph_tacf_pkg::unit_req_type mul_req, div_req, sqrt_req;
   sph_tacf_pkg::unit_rsp_type mul_rsp, div_rsp, sqrt_rsp;
   logic                       unit_done;
   logic [63:0]                unit_result;
   logic [63:0]                res_shr;
   logic [31:0]                w_val;
   logic [31:0]                poly_val;
   logic [63:0]                dot_term;
   logic [63:0]                dot_mag;
   logic [63:0]                dot_q;
   logic [32:0]                ta_sum;
   logic [32:0]                cf_sum;
   logic [64:0]                ta_wide;
   logic [64:0]                cf_wide;

   logic [31:0] in_pos [3];
   logic [31:0] in_vel [3];

   assign in_pos[0] = req_rel_pos_x;
   assign in_pos[1] = req_rel_pos_y;
   assign in_pos[2] = req_rel_pos_z;
   assign in_vel[0] = req_rel_vel_x;
   assign in_vel[1] = req_rel_vel_y;
   assign in_vel[2] = req_rel_vel_z;

   assign w_val    = (q_ff <= FX_ONE) ? 32'(FX_ONE - q_ff) : 32'd0;
   assign poly_val = 32'((q_ff << 1) + FX_ONE);

   // Operand selection for the unit that the current step uses.
   always_comb begin
      op_kind = OP_NONE;
      op_a    = 64'd0;
      op_b    = 32'd0;
      unique case (state_ff)
         S_SQP: begin
            op_kind = OP_MUL;
            op_a    = {32'd0, pmag_ff[k_ff]};
            op_b    = pmag_ff[k_ff];
         end
         S_SQV: begin
            op_kind = OP_MUL;
            op_a    = {32'd0, vmag_ff[k_ff]};
            op_b    = vmag_ff[k_ff];
         end
         S_RTP, S_RTV: begin
            op_kind = OP_SQRT;
            op_a    = sum_ff;
         end
         S_MQ: begin
            op_kind = OP_MUL;
            op_a    = {33'd0, inv_smooth_ff};
            op_b    = r_ff;
         end
         S_DV: begin
            op_kind = OP_DIV;
            op_a    = {32'd0, vmag_ff[k_ff]} << FRAC_BITS;
            op_b    = mv_ff;
         end
         S_DP: begin
            op_kind = OP_DIV;
            op_a    = {32'd0, pmag_ff[k_ff]} << FRAC_BITS;
            op_b    = r_ff;
         end
         S_MD: begin
            op_kind = OP_MUL;
            op_a    = uv_ff;
            op_b    = up_ff[31:0];
         end
         S_ME: begin
            op_kind = OP_MUL;
            op_a    = {32'd0, mv_ff};
            op_b    = e_ff;
         end
         S_MW: begin
            op_kind = OP_MUL;
            op_a    = tmp_ff;
            op_b    = w_val;
         end
         S_MT2, S_MT4: begin
            op_kind = OP_MUL;
            op_a    = tmp_ff;
            op_b    = tmp_ff[31:0];
         end
         S_MK: begin
            op_kind = OP_MUL;
            op_a    = tmp_ff;
            op_b    = poly_val;
         end
         S_MC: begin
            op_kind = OP_MUL;
            op_a    = {33'd0, color_scale_ff};
            op_b    = tmp_ff[31:0];
         end
         S_DC: begin
            op_kind = OP_DIV;
            op_a    = tmp_ff;
            op_b    = (rho_ff == 32'd0) ? 32'd1 : rho_ff;
         end
         default: ;
      endcase
   end

   assign mul_req.start  = (op_kind == OP_MUL) && !issued_ff;
   assign mul_req.a      = op_a;
   assign mul_req.b      = op_b;
   assign div_req.start  = (op_kind == OP_DIV) && !issued_ff;
   assign div_req.a      = op_a;
   assign div_req.b      = op_b;
   assign sqrt_req.start = (op_kind == OP_SQRT) && !issued_ff;
   assign sqrt_req.a     = op_a;
   assign sqrt_req.b     = op_b;

   sph_tacf_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   sph_tacf_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   sph_tacf_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));

   always_comb begin
      unit_done   = 1'b0;
      unit_result = 64'd0;
      unique case (op_kind)
         OP_MUL: begin
            unit_done   = mul_rsp.done;
            unit_result = mul_rsp.result;
         end
         OP_DIV: begin
            unit_done   = div_rsp.done;
            unit_result = div_rsp.result;
         end
         OP_SQRT: begin
            unit_done   = sqrt_rsp.done;
            unit_result = sqrt_rsp.result;
         end
         default: ;
      endcase
   end

   assign res_shr  = unit_result >> FRAC_BITS;
   assign dot_term = uneg_ff ? (64'd0 - unit_result) : unit_result;
   assign dot_mag  = dot_ff[63] ? (64'd0 - dot_ff) : dot_ff;
   assign dot_q    = dot_mag >> FRAC_BITS;
   assign ta_wide  = {33'd0, ta_acc_ff} + {1'b0, res_shr};
   assign cf_wide  = {33'd0, cf_acc_ff} + {1'b0, unit_result};
   assign ta_sum   = (ta_wide[64:32] != 33'd0) ? {1'b0, sph_tacf_pkg::SAT32} : ta_wide[32:0];
   assign cf_sum   = (cf_wide[64:32] != 33'd0) ? {1'b0, sph_tacf_pkg::SAT32} : cf_wide[32:0];

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      k_in         = k_ff;
      pmag_in      = pmag_ff;
      vmag_in      = vmag_ff;
      pneg_in      = pneg_ff;
      vneg_in      = vneg_ff;
      rho_in       = rho_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      mv_in        = mv_ff;
      q_in         = q_ff;
      uv_in        = uv_ff;
      up_in        = up_ff;
      uneg_in      = uneg_ff;
      dot_in       = dot_ff;
      e_in         = e_ff;
      tmp_in       = tmp_ff;
      ta_acc_in    = ta_acc_ff;
      cf_acc_in    = cf_acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ta_in    = rsp_ta_ff;
      rsp_cf_in    = rsp_cf_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Every unit step issues once, then waits for the unit's done beat.
      if (op_kind != OP_NONE) begin
         if (!issued_ff) begin
            issued_in = 1'b1;
         end else if (unit_done) begin
            issued_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  pneg_in[i] = in_pos[i][31];
                  vneg_in[i] = in_vel[i][31];
                  pmag_in[i] = in_pos[i][31] ? (32'd0 - in_pos[i]) : in_pos[i];
                  vmag_in[i] = in_vel[i][31] ? (32'd0 - in_vel[i]) : in_vel[i];
               end
               rho_in   = req_neighbour_density;
               last_in  = req_last_neighbour;
               k_in     = 2'd0;
               sum_in   = 64'd0;
               state_in = req_self_pair ? S_END : S_SQP;
            end
         end
         S_SQP, S_SQV: begin
            if (issued_ff && unit_done) begin
               sum_in = sum_ff + unit_result;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = (state_ff == S_SQP) ? S_RTP : S_RTV;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_RTP: begin
            if (issued_ff && unit_done) begin
               r_in     = unit_result[31:0];
               sum_in   = 64'd0;
               state_in = S_SQV;
            end
         end
         S_RTV: begin
            if (issued_ff && unit_done) begin
               mv_in    = unit_result[31:0];
               state_in = S_MQ;
            end
         end
         S_MQ: begin
            if (issued_ff && unit_done) begin
               q_in     = res_shr;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (r_ff <= {1'b0, smooth_ff} && mv_ff != 32'd0) begin
               if (r_ff != 32'd0) begin
                  k_in     = 2'd0;
                  dot_in   = 64'd0;
                  state_in = S_DV;
               end else begin
                  // Coincident particles: the direction term is taken as one.
                  e_in     = 32'(FX_ONE);
                  state_in = S_ME;
               end
            end else begin
               state_in = S_CCHK;
            end
         end
         S_DV: begin
            if (issued_ff && unit_done) begin
               uv_in    = unit_result;
               state_in = S_DP;
            end
         end
         S_DP: begin
            if (issued_ff && unit_done) begin
               up_in    = unit_result;
               uneg_in  = pneg_ff[k_ff] ^ vneg_ff[k_ff];
               state_in = S_MD;
            end
         end
         S_MD: begin
            if (issued_ff && unit_done) begin
               dot_in = dot_ff + dot_term;
               if (k_ff == 2'd2) begin
                  state_in = S_ECALC;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_DV;
               end
            end
         end
         S_ECALC: begin
            // One minus the cosine, clamped to the range zero to two.
            if (dot_ff[63]) begin
               e_in = (FX_ONE + dot_q > FX_TWO) ? 32'(FX_TWO) : 32'(FX_ONE + dot_q);
            end else begin
               e_in = (dot_q > FX_ONE) ? 32'd0 : 32'(FX_ONE - dot_q);
            end
            state_in = S_ME;
         end
         S_ME: begin
            if (issued_ff && unit_done) begin
               tmp_in   = res_shr;
               state_in = S_MW;
            end
         end
         S_MW: begin
            if (issued_ff && unit_done) begin
               ta_acc_in = ta_sum[31:0];
               state_in  = S_CCHK;
            end
         end
         S_CCHK: begin
            if (q_ff <= FX_TWO) begin
               tmp_in   = FX_ONE - (q_ff >> 1);
               state_in = S_MT2;
            end else begin
               state_in = S_END;
            end
         end
         S_MT2: begin
            if (issued_ff && unit_done) begin
               tmp_in   = res_shr;
               state_in = S_MT4;
            end
         end
         S_MT4: begin
            if (issued_ff && unit_done) begin
               tmp_in   = res_shr;
               state_in = S_MK;
            end
         end
         S_MK: begin
            if (issued_ff && unit_done) begin
               tmp_in   = res_shr;
               state_in = S_MC;
            end
         end
         S_MC: begin
            if (issued_ff && unit_done) begin
               tmp_in   = unit_result;
               state_in = S_DC;
            end
         end
         S_DC: begin
            if (issued_ff && unit_done) begin
               cf_acc_in = cf_sum[31:0];
               state_in  = S_END;
            end
         end
         S_END: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ta_in    = ta_acc_ff;
               rsp_cf_in    = cf_acc_ff;
               ta_acc_in    = 32'd0;
               cf_acc_in    = 32'd0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         ta_acc_ff    <= 32'd0;
         cf_acc_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         ta_acc_ff    <= ta_acc_in;
         cf_acc_ff    <= cf_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff      <= k_in;
      pmag_ff   <= pmag_in;
      vmag_ff   <= vmag_in;
      pneg_ff   <= pneg_in;
      vneg_ff   <= vneg_in;
      rho_ff    <= rho_in;
      last_ff   <= last_in;
      sum_ff    <= sum_in;
      r_ff      <= r_in;
      mv_ff     <= mv_in;
      q_ff      <= q_in;
      uv_ff     <= uv_in;
      up_ff     <= up_in;
      uneg_ff   <= uneg_in;
      dot_ff    <= dot_in;
      e_ff      <= e_in;
      tmp_ff    <= tmp_in;
      rsp_ta_ff <= rsp_ta_in;
      rsp_cf_ff <= rsp_cf_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_trapped_air_sum = rsp_ta_ff;
   assign rsp_color_field_sum = rsp_cf_ff;

   `SPH_TACF_ASSERT_NOW(a_idle_no_unit, clock, reset, state_ff == S_IDLE, !issued_ff)
   `SPH_TACF_ASSERT_NEXT(a_self_skips, clock, reset,
      req_valid && req_ready && req_self_pair, state_ff == S_END)
   `SPH_TACF_ASSERT_NEXT(a_emit_beat, clock, reset,
      state_ff == S_END && last_ff && !rsp_valid_ff, rsp_valid_ff)
   `SPH_TACF_ASSERT_NEXT(a_emit_clears, clock, reset,
      state_ff == S_END && last_ff && !rsp_valid_ff, ta_acc_ff == 32'd0 && cf_acc_ff == 32'd0)

endmodule

>>> tb/tb_sph_tacf_checker.sv
// Checker for the trapped-air and colour-field accumulator: predicts sums and compares beats.
`timescale 1ns / 1ps

module tb_sph_tacf_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [31:0]                              req_rel_pos_x,
   input  logic [31:0]                              req_rel_pos_y,
   input  logic [31:0]                              req_rel_pos_z,
   input  logic [31:0]                              req_rel_vel_x,
   input  logic [31:0]                              req_rel_vel_y,
   input  logic [31:0]                              req_rel_vel_z,
   input  logic [31:0]                              req_neighbour_density,
   input  logic                                     req_self_pair,
   input  logic                                     req_last_neighbour,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic [31:0]                              rsp_trapped_air_sum,
   input  logic [31:0]                              rsp_color_field_sum,
   input  logic                                     csr_we,
   input  logic [sph_tacf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                       fail_count,
   output int                                       pending,
   output int                                       sums_seen
);

   localparam int FB = sph_tacf_pkg::FRAC_BITS_DEFAULT;
   localparam logic [63:0] FX_ONE = 64'd1 << FB;

   typedef struct packed {
      logic [31:0] trapped_air;
      logic [31:0] color_field;
   } sums_type;

   sums_type                                expected_sums[$];
   logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] kernel_radius, inv_radius, colour_scale;
   logic [31:0]                             trapped_air_total, colour_total;

   function automatic logic [63:0] square_mag(logic [31:0] c);
      longint      s;
      logic [63:0] u;
      s = longint'($signed(c));
      u = (s < 0) ? 64'(-s) : 64'(s);
      return u * u;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (x >= root + bit_val) begin
            x = x - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   // Unit component, truncated toward zero as signed division does.
   function automatic longint unit_part(logic [31:0] c, logic [63:0] mag);
      return (longint'($signed(c)) * longint'(FX_ONE)) / longint'(mag);
   endfunction

   function automatic logic [31:0] sat_add(logic [31:0] acc, logic [63:0] add);
      logic [64:0] s;
      s = {33'd0, acc} + {1'b0, add};
      return (s > 65'hFFFF_FFFF) ? sph_tacf_pkg::SAT32 : s[31:0];
   endfunction

   task automatic accumulate_pair();
      logic [63:0] pair_r, q, speed, w, t, t2, t4, poly, kern, rho;
      longint      dot, e;
      pair_r = int_sqrt(square_mag(req_rel_pos_x) + square_mag(req_rel_pos_y)
                        + square_mag(req_rel_pos_z));
      q = (pair_r * {33'd0, inv_radius}) >> FB;
      if (pair_r <= {33'd0, kernel_radius}) begin
         speed = int_sqrt(square_mag(req_rel_vel_x) + square_mag(req_rel_vel_y)
                          + square_mag(req_rel_vel_z));
         if (speed != 0) begin
            e = longint'(FX_ONE);
            if (pair_r != 0) begin
               dot = unit_part(req_rel_vel_x, speed) * unit_part(req_rel_pos_x, pair_r)
                   + unit_part(req_rel_vel_y, speed) * unit_part(req_rel_pos_y, pair_r)
                   + unit_part(req_rel_vel_z, speed) * unit_part(req_rel_pos_z, pair_r);
               e = longint'(FX_ONE) - dot / longint'(FX_ONE);
               if (e < 0) e = 0;
               if (e > 2 * longint'(FX_ONE)) e = 2 * longint'(FX_ONE);
            end
            w = (q <= FX_ONE) ? FX_ONE - q : 64'd0;
            t = (speed * 64'(e)) >> FB;
            t = (t * w) >> FB;
            trapped_air_total = sat_add(trapped_air_total, t);
         end
      end
      if (q <= 2 * FX_ONE) begin
         t    = FX_ONE - (q >> 1);
         t2   = (t * t) >> FB;
         t4   = (t2 * t2) >> FB;
         poly = (q << 1) + FX_ONE;
         kern = (t4 * poly) >> FB;
         rho  = (req_neighbour_density == 0) ? 64'd1 : {32'd0, req_neighbour_density};
         colour_total = sat_add(colour_total, ({33'd0, colour_scale} * kern) / rho);
      end
   endtask

   always @(posedge clock) begin
      sums_type got, want, due;
      int       errs;
      errs = 0;
      if (reset) begin
         kernel_radius     = sph_tacf_pkg::SMOOTHING_LENGTH_RESET;
         inv_radius        = sph_tacf_pkg::INV_SMOOTHING_LENGTH_RESET;
         colour_scale      = sph_tacf_pkg::COLOR_SCALE_RESET;
         trapped_air_total = 0;
         colour_total      = 0;
         expected_sums.delete();
         fail_count <= 0;
         sums_seen  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sph_tacf_pkg::CSR_SMOOTHING_LENGTH:     kernel_radius = csr_wdata;
               sph_tacf_pkg::CSR_INV_SMOOTHING_LENGTH: inv_radius    = csr_wdata;
               sph_tacf_pkg::CSR_COLOR_SCALE:          colour_scale  = csr_wdata;
               default: ;
            endcase
         end
         // The result beat at this edge belongs to an earlier pair, so it is popped first.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_trapped_air_sum, rsp_color_field_sum};
            sums_seen <= sums_seen + 1;
            if (expected_sums.size() == 0) begin
               $error("result beat with no sums expected: %h %h",
                      got.trapped_air, got.color_field);
               errs++;
            end else begin
               want = expected_sums.pop_front();
               if (got.trapped_air !== want.trapped_air) begin
                  $error("trapped_air_sum: expected %h actual %h",
                         want.trapped_air, got.trapped_air);
                  errs++;
               end
               if (got.color_field !== want.color_field) begin
                  $error("color_field_sum: expected %h actual %h",
                         want.color_field, got.color_field);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (!req_self_pair) accumulate_pair();
            if (req_last_neighbour) begin
               due = '{trapped_air_total, colour_total};
               expected_sums.insert(expected_sums.size(), due);
               trapped_air_total = 0;
               colour_total      = 0;
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= expected_sums.size();
   end

endmodule

>>> tb/tb_sph_trapped_air_colorfield_accum_core.sv
// Top of the accumulator testbench: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps

module tb_sph_trapped_air_colorfield_accum_core;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int DRAIN_CYCLES = 1500;

   logic                                     clock, reset;
   logic                                     req_valid, req_ready;
   logic [31:0]                              req_rel_pos_x, req_rel_pos_y, req_rel_pos_z;
   logic [31:0]                              req_rel_vel_x, req_rel_vel_y, req_rel_vel_z;
   logic [31:0]                              req_neighbour_density;
   logic                                     req_self_pair, req_last_neighbour;
   logic                                     rsp_valid, rsp_ready;
   logic [31:0]                              rsp_trapped_air_sum, rsp_color_field_sum;
   logic                                     csr_we;
   logic [sph_tacf_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                                       fail_count, pending, sums_seen;
   int                                       cycle_count, pairs_sent;
   logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0]  radius_now;
   logic                                     calm;

   sph_trapped_air_colorfield_accum_core u_top (
      .clock, .reset, .req_valid, .req_ready,
      .req_rel_pos_x($signed(req_rel_pos_x)), .req_rel_pos_y($signed(req_rel_pos_y)),
      .req_rel_pos_z($signed(req_rel_pos_z)), .req_rel_vel_x($signed(req_rel_vel_x)),
      .req_rel_vel_y($signed(req_rel_vel_y)), .req_rel_vel_z($signed(req_rel_vel_z)),
      .req_neighbour_density, .req_self_pair, .req_last_neighbour,
      .rsp_valid, .rsp_ready, .rsp_trapped_air_sum, .rsp_color_field_sum,
      .csr_we, .csr_index, .csr_wdata
   );

   tb_sph_tacf_checker u_checker (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // A long calm stretch in the middle of the run has no idling on either side.
   assign calm = (cycle_count >= 150000) && (cycle_count < 300000);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= calm || ($urandom_range(99) >= 7);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_pair(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                            logic [31:0] rho, logic self_flag, logic last_flag);
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid             <= 1'b1;
      req_rel_pos_x         <= px;
      req_rel_pos_y         <= py;
      req_rel_pos_z         <= pz;
      req_rel_vel_x         <= vx;
      req_rel_vel_y         <= vy;
      req_rel_vel_z         <= vz;
      req_neighbour_density <= rho;
      req_self_pair         <= self_flag;
      req_last_neighbour    <= last_flag;
      do @(posedge clock); while (!req_ready);
      pairs_sent++;
   endtask

   // Lets the block drain completely, then writes all three registers.
   task automatic set_registers(logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] h,
                                logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] inv_h,
                                logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] scale);
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1; csr_index <= sph_tacf_pkg::CSR_SMOOTHING_LENGTH; csr_wdata <= h;
      @(posedge clock);
      csr_index <= sph_tacf_pkg::CSR_INV_SMOOTHING_LENGTH; csr_wdata <= inv_h;
      @(posedge clock);
      csr_index <= sph_tacf_pkg::CSR_COLOR_SCALE;          csr_wdata <= scale;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_now = h;
   endtask

   // Coordinates mostly lie inside the kernel support, with full-range noise.
   function automatic logic [31:0] pick_coord(logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] h);
      longint span;
      int     mode;
      mode = $urandom_range(99);
      span = (h > 31'h3FFF_FFFF) ? 64'h3FFF_FFFF : longint'(h);
      if (mode < 65) return 32'(longint'($urandom_range(32'(2 * span))) - span);
      if (mode < 80) return 32'($signed($urandom_range(512)) - 256);
      return $urandom;
   endfunction

   task automatic send_particle(logic [sph_tacf_pkg::CSR_DATA_WIDTH-1:0] h, int n);
      int          self_at, k;
      logic [31:0] vx, vy, vz, rho;
      self_at = $urandom_range(n - 1);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) begin
            vx = 0; vy = 0; vz = 0;
         end else begin
            vx = pick_coord(h); vy = pick_coord(h); vz = pick_coord(h);
         end
         case ($urandom_range(9))
            0:       rho = 0;
            1:       rho = $urandom;
            default: rho = $urandom_range(32'h0004_0000, 32'h0000_8000);
         endcase
         // Occasional broken groups carry a stray self pair or an early end.
         send_pair(pick_coord(h), pick_coord(h), pick_coord(h), vx, vy, vz, rho,
                   (k == self_at) || ($urandom_range(19) == 0),
                   (k == n - 1) || ($urandom_range(39) == 0));
      end
   endtask

   initial begin
      int phase;
      cycle_count = 0; pairs_sent = 0;
      reset = 1'b1; req_valid = 1'b0; rsp_ready = 1'b0; csr_we = 1'b0;
      csr_index = sph_tacf_pkg::CSR_SMOOTHING_LENGTH; csr_wdata = '0;
      req_rel_pos_x = 0; req_rel_pos_y = 0; req_rel_pos_z = 0;
      req_rel_vel_x = 0; req_rel_vel_y = 0; req_rel_vel_z = 0;
      req_neighbour_density = 32'h0001_0000; req_self_pair = 0; req_last_neighbour = 0;
      radius_now = sph_tacf_pkg::SMOOTHING_LENGTH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs at the reset settings.
      send_pair(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1);      // zero distance
      send_pair(32'h0000_4000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 1);      // zero velocity
      send_pair(32'h0000_4000, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 1);      // zero density
      send_pair(32'h0000_4000, 0, 0, 32'hFFFF_0000, 0, 0, 32'hFFFF_FFFF, 0, 0);
      send_pair(32'h0001_0000, 0, 0, 32'h0000_8000, 32'h0000_8000, 0, 1, 0, 0); // r = h
      send_pair(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1); // q = 2
      send_pair(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_7000,
                32'h0000_7000, 32'h0000_7000, 32'h0001_0000, 0, 1);      // parallel, cos near 1
      send_pair(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_9000,
                32'hFFFF_9000, 32'hFFFF_9000, 32'h0001_0000, 0, 1);      // opposed, cos near -1
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0, 1);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1);
      send_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 0);                  // self pair
      send_pair(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1, 1);      // self pair flagged last
      send_pair(32'h0000_0100, 0, 0, 32'h0000_0100, 0, 0, 0, 0, 1);
      // Large colour scale and tiny density drive both sums into saturation.
      set_registers(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
      repeat (6) send_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0, 0);
      send_pair(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 0, 1);
      set_registers(31'd1, 31'h7FFF_FFFF, 31'd0);
      send_pair(1, 0, 0, 1, 0, 0, 1, 0, 0);
      send_pair(0, 0, 0, 32'h0000_0005, 0, 0, 1, 0, 1);
      send_pair(32'h0000_0003, 0, 0, 1, 0, 0, 1, 0, 1);

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_registers(sph_tacf_pkg::SMOOTHING_LENGTH_RESET,
                             sph_tacf_pkg::INV_SMOOTHING_LENGTH_RESET,
                             sph_tacf_pkg::COLOR_SCALE_RESET);
            1: set_registers(31'h0002_0000, 31'h0000_8000, 31'($urandom));
            2: set_registers(31'd1, 31'h7FFF_FFFF, 31'd0);
            3: set_registers(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
            4: set_registers(31'h0000_4000, 31'h0004_0000, 31'h0001_0000);
            default: set_registers(31'($urandom_range(32'h0010_0000, 32'h0000_1000)),
                                   31'($urandom_range(32'h0010_0000, 32'h0000_1000)),
                                   31'($urandom));
         endcase
         while (pairs_sent < 20 + (phase + 1) * 135)
            send_particle(radius_now, $urandom_range(8, 1));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d neighbour pairs over six register settings plus directed cases;",
               pairs_sent);
      $display("checked %0d accumulated sum beats, %0d mismatches.", sums_seen, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
